>>> src/tnfm_pkg.sv
// Shared constants and types for the temporal nine-frame mean block.
// Used by tnfm_frame_bank and temporal_nine_frame_mean; depends on nothing.
`timescale 1ns / 1ps

package tnfm_pkg;

    // Frame geometry and history depth
    localparam int MAX_FRAME_BYTES = 65536;
    localparam int HISTORY_DEPTH   = 9;
    localparam int RESET_LEN       = 65536;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 17;
    localparam int POS_W  = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = $clog2(HISTORY_DEPTH * 255 + 1);

    // Divide by the history depth as multiply by a rounded-up reciprocal.
    // 2^RECIP_SHIFT exceeds HISTORY_DEPTH times the largest sum, so the
    // truncated product equals the exact floor of the quotient.
    localparam int RECIP_SHIFT = 2 * SUM_W;
    localparam int RECIP_W     = RECIP_SHIFT;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [RECIP_W-1:0] recip_t;
    typedef logic [PROD_W-1:0]  prod_t;

    localparam recip_t RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

    localparam slot_t LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

    localparam pos_t RESET_LAST_POS =
        POS_W'(((RESET_LEN < MAX_FRAME_BYTES) ? RESET_LEN : MAX_FRAME_BYTES) - 1);

endpackage

>>> src/tnfm_frame_bank.sv
// One frame store of the history ring: a single-port synchronous memory,
// one byte per frame position, registered read. Depends on tnfm_pkg.
`timescale 1ns / 1ps

module tnfm_frame_bank (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic          wr_en,
    input  tnfm_pkg::pos_t  addr,
    input  tnfm_pkg::byte_t wr_data,
    output tnfm_pkg::byte_t rd_data
);
    import tnfm_pkg::*;

    byte_t mem [MAX_FRAME_BYTES];

    // Write the incoming byte; read returns the value held before this edge
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[addr];
        end
    end

endmodule

>>> src/temporal_nine_frame_mean.sv
// Top level of the temporal nine-frame mean: frame banks, position and slot
// control, and the sum and divide pipeline. Depends on tnfm_pkg, tnfm_frame_bank.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel s_valid / s_ready / s_pixel_byte carries one byte of a frame
//   per transaction, in raster order with no row padding. Output channel
//   m_valid / m_ready / m_out_byte / m_end_of_frame returns one transaction for
//   each input transaction, in order; m_end_of_frame marks the last byte.
//   cfg_wr_en / cfg_frame_bytes set the frame length (0 acts as 1, values over
//   the frame store size saturate); write it only while the block is idle.
//   Throughput is one byte per clock while the output is not stalled: each byte
//   writes its own bank and reads all nine banks at the same position, using the other eight.
//   m_valid follows the input transaction through three registers: bank read,
//   nine-way sum, reciprocal multiply.
//   For the first eight frames after reset bytes pass through unchanged; from
//   the ninth frame on each byte is the truncated mean over nine frames.
//   Reset clears slot, position, fill state, pipeline valids and sets the frame
//   length to 65536. Bank contents are not cleared.
//   When m_ready is low with m_valid high the whole pipeline holds and s_ready
//   drops in the same cycle; nothing is lost.
//
module temporal_nine_frame_mean (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [16:0]            cfg_frame_bytes,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tnfm_pkg::byte_t        s_pixel_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tnfm_pkg::byte_t        m_out_byte,
    output logic                   m_end_of_frame
);
    import tnfm_pkg::*;

    logic        advance;
    logic        accept;
    logic        is_last;
    logic        avg_en;
    logic [31:0] cfg_ext;
    pos_t        last_pos_next;

    pos_t        pos_reg,      pos_next;
    slot_t       slot_reg,     slot_next;
    logic        full_reg,     full_next;
    pos_t        last_pos_reg;

    byte_t       bank_rd [HISTORY_DEPTH];

    logic        v1_reg, v2_reg, m_valid_reg;
    byte_t       px1_reg, px2_reg;
    slot_t       slot1_reg;
    logic        avg1_reg, avg2_reg;
    logic        last1_reg, last2_reg;
    sum_t        sum2_reg, sum2_next;
    prod_t       prod;
    byte_t       out_byte_reg;
    logic        eof_reg;

    // Move the whole pipeline unless the output is stalled
    assign advance = !m_valid_reg || m_ready;
    assign accept  = s_valid && advance;
    assign s_ready = advance;

    // Clamp the written frame length to the position of its last byte
    assign cfg_ext = 32'(cfg_frame_bytes);
    always_comb begin
        if (cfg_ext == 32'd0) begin
            last_pos_next = '0;
        end else if (cfg_ext > 32'(MAX_FRAME_BYTES)) begin
            last_pos_next = POS_W'(MAX_FRAME_BYTES - 1);
        end else begin
            last_pos_next = POS_W'(cfg_ext - 32'd1);
        end
    end

    // Advance position within the frame, and the slot at frame end
    assign is_last = (pos_reg >= last_pos_reg);
    assign avg_en  = full_reg || (slot_reg == LAST_SLOT);

    always_comb begin
        pos_next  = pos_reg;
        slot_next = slot_reg;
        full_next = full_reg;
        if (accept) begin
            if (is_last) begin
                pos_next = '0;
                if (slot_reg == LAST_SLOT) begin
                    slot_next = '0;
                    full_next = 1'b1;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            slot_reg     <= '0;
            full_reg     <= 1'b0;
            last_pos_reg <= RESET_LAST_POS;
        end else begin
            pos_reg  <= pos_next;
            slot_reg <= slot_next;
            full_reg <= full_next;
            if (cfg_wr_en) begin
                last_pos_reg <= last_pos_next;
            end
        end
    end

    // Frame banks: write the current slot, read every slot at this position
    for (genvar b = 0; b < HISTORY_DEPTH; b++) begin : g_bank
        tnfm_frame_bank u_bank (
            .aclk    (aclk),
            .rd_en   (advance),
            .wr_en   (accept && (slot_reg == SLOT_W'(b))),
            .addr    (pos_reg),
            .wr_data (s_pixel_byte),
            .rd_data (bank_rd[b])
        );
    end

    // Sum the eight stored frames with the current byte in place of its own bank
    always_comb begin
        sum2_next = sum_t'(px1_reg);
        for (int b = 0; b < HISTORY_DEPTH; b++) begin
            if (slot1_reg != SLOT_W'(b)) begin
                sum2_next = sum2_next + sum_t'(bank_rd[b]);
            end
        end
    end

    // Divide by the history depth
    assign prod = prod_t'(sum2_reg) * prod_t'(RECIP);

    // Pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg      <= accept;
            v2_reg      <= v1_reg;
            m_valid_reg <= v2_reg;
        end
    end

    // Pipeline payload; hold while stalled
    always_ff @(posedge aclk) begin
        if (advance) begin
            px1_reg   <= s_pixel_byte;
            slot1_reg <= slot_reg;
            avg1_reg  <= avg_en;
            last1_reg <= is_last;

            px2_reg   <= px1_reg;
            sum2_reg  <= sum2_next;
            avg2_reg  <= avg1_reg;
            last2_reg <= last1_reg;

            out_byte_reg <= avg2_reg ? prod[RECIP_SHIFT +: BYTE_W] : px2_reg;
            eof_reg      <= last2_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_end_of_frame = eof_reg;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for temporal_nine_frame_mean: a scoreboard class predicts
// each output byte and end-of-frame flag. Depends on tnfm_pkg and the block's RTL.

module tb_top;
    import tnfm_pkg::*;

    // Every slot is filled to at least this many bytes before averaging starts
    localparam int COVERED_LEN   = 24;
    localparam int FILL_EXTRA    = 40;
    localparam int RANDOM_PIXELS = 1040;
    localparam int MAX_BURST     = 60;

    typedef enum int {
        IDLE_SENDER_LIGHT,
        IDLE_RECEIVER_LIGHT,
        IDLE_NONE
    } idle_mode_t;

    typedef enum int {
        FILL_UNIFORM,
        FILL_ONES,
        FILL_ZEROS
    } fill_style_t;

    typedef struct packed {
        byte_t out_byte;
        logic  end_of_frame;
    } frame_out_t;

    // Tracks the frame ring and predicts one output transaction per input byte
    class frame_mean_scoreboard;
        logic [LEN_W-1:0] frame_bytes_reg;
        int unsigned      ring_slot;
        bit               ring_full;
        int unsigned      byte_pos;
        byte_t            store[int unsigned];
        frame_out_t       expected_q[$];
        int unsigned      mismatches;
        int unsigned      pixels_in;
        int unsigned      bytes_checked;
        int unsigned      frames_seen;

        function new();
            frame_bytes_reg = LEN_W'(RESET_LEN);
            ring_slot       = 0;
            ring_full       = 1'b0;
            byte_pos        = 0;
            mismatches      = 0;
            pixels_in       = 0;
            bytes_checked   = 0;
            frames_seen     = 0;
        endfunction

        function void set_frame_bytes(logic [LEN_W-1:0] value);
            frame_bytes_reg = value;
        endfunction

        // Zero acts as one; anything above the store size saturates
        function int unsigned active_length();
            int unsigned n;
            n = frame_bytes_reg;
            if (n == 0)
                n = 1;
            if (n > MAX_FRAME_BYTES)
                n = MAX_FRAME_BYTES;
            return n;
        endfunction

        // Truncated mean of one position across all slots
        function byte_t nine_frame_mean(int unsigned pos);
            int unsigned sum;
            int unsigned key;
            sum = 0;
            for (int s = 0; s < HISTORY_DEPTH; s++) begin
                key = s * MAX_FRAME_BYTES + pos;
                if (store.exists(key))
                    sum += store[key];
            end
            return byte_t'(sum / HISTORY_DEPTH);
        endfunction

        function void accept_pixel(byte_t px);
            frame_out_t  exp_out;
            bit          last;
            store[ring_slot * MAX_FRAME_BYTES + byte_pos] = px;
            // The frame in the last slot already averages, before the ring is full
            if (ring_full || ring_slot == HISTORY_DEPTH - 1)
                exp_out.out_byte = nine_frame_mean(byte_pos);
            else
                exp_out.out_byte = px;
            last = (byte_pos + 1 >= active_length());
            exp_out.end_of_frame = last;
            expected_q.push_back(exp_out);
            pixels_in++;
            // Advance position, or wrap to the next slot at the end of a frame
            if (last) begin
                byte_pos = 0;
                ring_slot++;
                if (ring_slot >= HISTORY_DEPTH) begin
                    ring_slot = 0;
                    ring_full = 1'b1;
                end
            end else begin
                byte_pos++;
            end
        endfunction

        function void check_output(byte_t out_byte, logic end_of_frame);
            frame_out_t exp_out;
            if (expected_q.size() == 0) begin
                $display("%0t: output transaction with nothing expected: out_byte %02h eof %0b",
                         $time, out_byte, end_of_frame);
                mismatches++;
                return;
            end
            exp_out = expected_q.pop_front();
            bytes_checked++;
            if (end_of_frame)
                frames_seen++;
            if (out_byte !== exp_out.out_byte) begin
                $display("%0t: out_byte expected %02h, actual %02h",
                         $time, exp_out.out_byte, out_byte);
                mismatches++;
            end
            if (end_of_frame !== exp_out.end_of_frame) begin
                $display("%0t: end_of_frame expected %0b, actual %0b",
                         $time, exp_out.end_of_frame, end_of_frame);
                mismatches++;
            end
        endfunction
    endclass

    logic             aclk            = 1'b0;
    logic             aresetn         = 1'b0;
    logic             cfg_wr_en       = 1'b0;
    logic [LEN_W-1:0] cfg_frame_bytes = '0;
    logic             s_valid         = 1'b0;
    logic             s_ready;
    byte_t            s_pixel_byte    = '0;
    logic             m_valid;
    logic             m_ready         = 1'b0;
    byte_t            m_out_byte;
    logic             m_end_of_frame;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    frame_mean_scoreboard mean_sb = new();

    temporal_nine_frame_mean dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_frame_bytes (cfg_frame_bytes),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_byte    (s_pixel_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_end_of_frame  (m_end_of_frame)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Note input transactions before checking output transactions of the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                mean_sb.accept_pixel(s_pixel_byte);
            if (m_valid && m_ready)
                mean_sb.check_output(m_out_byte, m_end_of_frame);
        end
    end

    // Stall the output side at random
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER_LIGHT: begin
                send_idle_pct = 14;
                recv_idle_pct = 50;
            end
            IDLE_RECEIVER_LIGHT: begin
                send_idle_pct = 50;
                recv_idle_pct = 14;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    function automatic byte_t pick_pixel(input fill_style_t style);
        case (style)
            FILL_ONES:  return ($urandom_range(7) == 0) ? byte_t'($urandom_range(255)) : 8'hFF;
            FILL_ZEROS: return ($urandom_range(7) == 0) ? byte_t'($urandom_range(255)) : 8'h00;
            default:    return byte_t'($urandom_range(255));
        endcase
    endfunction

    // Hold valid and payload until the transaction is taken
    task automatic send_pixel(input byte_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pixel_byte <= px;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic send_burst(input int unsigned count, input fill_style_t style);
        for (int i = 0; i < count; i++)
            send_pixel(pick_pixel(style));
    endtask

    // Drop valid, let the last accepted byte reach the scoreboard, then wait
    // until every expected output has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (mean_sb.expected_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_frame_bytes(input logic [LEN_W-1:0] value);
        cfg_wr_en       <= 1'b1;
        cfg_frame_bytes <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mean_sb.set_frame_bytes(value);
    endtask

    initial begin
        byte_t            extreme_bytes[8];
        int unsigned      fill_len;
        int unsigned      burst;
        int unsigned      random_sent;
        logic [LEN_W-1:0] next_len;
        bit               cut_due;

        extreme_bytes = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h55, 8'hAA};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_idle(IDLE_SENDER_LIGHT);

        // Slot 0: saturating length, extreme bytes, then cut short by a zero length
        write_frame_bytes('1);
        foreach (extreme_bytes[i])
            send_pixel(extreme_bytes[i]);
        send_burst(COVERED_LEN - 1 - 8, FILL_UNIFORM);
        drain();
        write_frame_bytes('0);
        send_pixel(8'hFF);
        drain();

        // Slot 1: exact store size, cut past the covered span
        write_frame_bytes(LEN_W'(MAX_FRAME_BYTES));
        send_burst(COVERED_LEN + 6, FILL_UNIFORM);
        drain();
        write_frame_bytes(LEN_W'(COVERED_LEN));
        send_pixel(pick_pixel(FILL_UNIFORM));
        drain();

        // Slots 2 to 7: pass-through frames at least as long as the covered span
        for (int s = 2; s < HISTORY_DEPTH - 1; s++) begin
            set_idle(idle_mode_t'(s % 3));
            fill_len = $urandom_range(COVERED_LEN, COVERED_LEN + FILL_EXTRA);
            write_frame_bytes(LEN_W'(fill_len));
            send_burst(fill_len, FILL_UNIFORM);
            drain();
        end

        // Last slot completes the ring; averaging starts here
        set_idle(IDLE_SENDER_LIGHT);
        write_frame_bytes(LEN_W'(COVERED_LEN));
        send_burst(COVERED_LEN, FILL_UNIFORM);
        drain();

        // One-byte frames of all ones: the mean reaches its top value
        write_frame_bytes(LEN_W'(1));
        for (int i = 0; i < 2 * HISTORY_DEPTH; i++)
            send_pixel(8'hFF);
        drain();

        // Random phases; lengths stay within the covered span except for short
        // runs under a long length that the next phase always cuts
        random_sent = 0;
        cut_due     = 1'b0;
        while (random_sent < RANDOM_PIXELS) begin
            set_idle(idle_mode_t'((random_sent * 3) / RANDOM_PIXELS));
            if (!cut_due && $urandom_range(7) == 0 && mean_sb.byte_pos < COVERED_LEN - 1) begin
                case ($urandom_range(2))
                    0:       next_len = '1;
                    1:       next_len = LEN_W'(MAX_FRAME_BYTES);
                    default: next_len = LEN_W'($urandom_range(COVERED_LEN + 1, MAX_FRAME_BYTES));
                endcase
                write_frame_bytes(next_len);
                burst   = $urandom_range(1, COVERED_LEN - 1 - mean_sb.byte_pos);
                cut_due = 1'b1;
            end else begin
                if (cut_due || $urandom_range(1) == 1) begin
                    case ($urandom_range(4))
                        0:       next_len = '0;
                        1:       next_len = LEN_W'(1);
                        2:       next_len = LEN_W'(COVERED_LEN);
                        default: next_len = LEN_W'($urandom_range(1, COVERED_LEN));
                    endcase
                    write_frame_bytes(next_len);
                end
                cut_due = 1'b0;
                burst   = $urandom_range(1, MAX_BURST);
            end
            send_burst(burst, fill_style_t'($urandom_range(2)));
            drain();
            random_sent += burst;
        end

        // Let the pipeline settle, then report
        repeat (8) @(posedge aclk);
        $display("Sent %0d bytes, checked %0d outputs over %0d frames.",
                 mean_sb.pixels_in, mean_sb.bytes_checked, mean_sb.frames_seen);
        $display("Lengths 0 to saturated, mid-frame cuts, ring fill and three stall mixes.");
        if (mean_sb.mismatches == 0 && mean_sb.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: end the run if it hangs
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
